// File: src/double_ended_queue_defines.svh
// assertion macros used by the double-ended queue back end
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// invariant checked on every edge outside reset
`define DEQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition on one edge implies a consequence on the next edge
`define DEQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/deq_pkg.sv
// shared types and constants of the double-ended queue
package deq_pkg;

   localparam int KIND_W   = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // request kinds as they arrive on the input beat
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRAVERSE   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // command queue between front and back
   localparam int CMD_SLOTS = 2;
   localparam int CMD_PTR_W = $clog2(CMD_SLOTS);
   localparam int CMD_LVL_W = $clog2(CMD_SLOTS + 1);

   // result queue at the output
   localparam int RSP_SLOTS = 4;
   localparam int RSP_PTR_W = $clog2(RSP_SLOTS);
   localparam int RSP_LVL_W = $clog2(RSP_SLOTS + 1);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_TRAVERSE   = 3'd4,
      OP_NOP        = 3'd5
   } deq_op_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] value;
   } deq_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] element;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     last;
   } deq_rsp_type;

   typedef struct packed {
      deq_op_type               op;
      logic signed [WORD_W-1:0] value;
   } deq_cmd_type;

endpackage

// File: src/deq_front.sv
// front end: accepts request beats, decodes the kind and queues commands
module deq_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  deq_pkg::deq_req_type req_data,
   output logic                cmd_valid,
   output deq_pkg::deq_cmd_type cmd_data,
   input  logic                cmd_take
);

   deq_pkg::deq_cmd_type                 slot_ff [deq_pkg::CMD_SLOTS];
   logic [deq_pkg::CMD_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [deq_pkg::CMD_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [deq_pkg::CMD_LVL_W-1:0]        level_ff, level_in;
   deq_pkg::deq_cmd_type                 decoded;
   logic                                 wr_fire;
   logic                                 rd_fire;

   // decode the request kind into a command
   always_comb begin
      decoded.value = req_data.value;
      case (req_data.kind)
         deq_pkg::KIND_PUSH_FRONT: decoded.op = deq_pkg::OP_PUSH_FRONT;
         deq_pkg::KIND_PUSH_BACK:  decoded.op = deq_pkg::OP_PUSH_BACK;
         deq_pkg::KIND_POP_FRONT:  decoded.op = deq_pkg::OP_POP_FRONT;
         deq_pkg::KIND_POP_BACK:   decoded.op = deq_pkg::OP_POP_BACK;
         deq_pkg::KIND_TRAVERSE:   decoded.op = deq_pkg::OP_TRAVERSE;
         default:                  decoded.op = deq_pkg::OP_NOP;
      endcase
   end

   assign full      = (level_ff == deq_pkg::CMD_LVL_W'(deq_pkg::CMD_SLOTS));
   assign cmd_valid = (level_ff != '0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign wr_fire   = push && !full;
   assign rd_fire   = cmd_take && cmd_valid;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == deq_pkg::CMD_PTR_W'(deq_pkg::CMD_SLOTS - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == deq_pkg::CMD_PTR_W'(deq_pkg::CMD_SLOTS - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
         level_in = level_ff + 1'b1;
      end else if (!wr_fire && rd_fire) begin
         level_in = level_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: src/deq_back.sv
// back end: holds the circular store and carries out one command step per cycle while the result queue has room
`include "double_ended_queue_defines.svh"

module deq_back #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  deq_pkg::deq_cmd_type          cmd_data,
   output logic                          cmd_take,
   input  logic [deq_pkg::RSP_LVL_W-1:0] rsp_level,
   output logic                          res_valid,
   output deq_pkg::deq_rsp_type          res_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   typedef struct packed {
      logic                             use_mem;
      logic [deq_pkg::STATUS_W-1:0]     status;
      logic [deq_pkg::OCC_W-1:0]        occupancy;
      logic                             is_empty;
      logic                             last;
   } deq_meta_type;

   logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];
   logic signed [deq_pkg::WORD_W-1:0] rd_data_ff;

   logic [IW-1:0]   front_ff, front_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   trav_ff, trav_in;
   logic            b_valid_ff, b_valid_in;
   deq_meta_type    b_meta_ff, b_meta_in;

   logic            issue;
   logic            is_full;
   logic            is_none;
   logic            trav_last;
   logic            wr_en;
   logic            rd_en;
   logic [IW-1:0]   wr_addr;
   logic [IW-1:0]   rd_addr;
   logic [deq_pkg::RSP_LVL_W:0] out_load;

   // slot at an offset from an index, wrapped into the store
   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(idx) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
      return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
      return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
   endfunction

   // issue only while the result queue has room for everything in flight
   assign out_load  = (deq_pkg::RSP_LVL_W + 1)'(rsp_level) +
                      (deq_pkg::RSP_LVL_W + 1)'(b_valid_ff);
   assign issue     = cmd_valid &&
                      (out_load < (deq_pkg::RSP_LVL_W + 1)'(deq_pkg::RSP_SLOTS));
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_none   = (count_ff == '0);
   assign trav_last = ((CW'(trav_ff) + 1'b1) == count_ff);

   // command step
   always_comb begin
      front_in          = front_ff;
      count_in          = count_ff;
      trav_in           = trav_ff;
      cmd_take          = 1'b0;
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      wr_addr           = front_ff;
      rd_addr           = front_ff;
      b_valid_in        = issue;
      b_meta_in.use_mem = 1'b0;
      b_meta_in.status  = deq_pkg::ST_OK;
      b_meta_in.last    = 1'b1;
      if (issue) begin
         case (cmd_data.op)
            deq_pkg::OP_PUSH_FRONT: begin
               cmd_take = 1'b1;
               if (is_full) begin
                  b_meta_in.status = deq_pkg::ST_FULL;
               end else begin
                  front_in = wrap_dec(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = wrap_dec(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_PUSH_BACK: begin
               cmd_take = 1'b1;
               if (is_full) begin
                  b_meta_in.status = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = wrap_add(front_ff, count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               cmd_take = 1'b1;
               if (is_none) begin
                  b_meta_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en             = 1'b1;
                  rd_addr           = front_ff;
                  b_meta_in.use_mem = 1'b1;
                  front_in          = wrap_inc(front_ff);
                  count_in          = count_ff - 1'b1;
               end
            end
            deq_pkg::OP_POP_BACK: begin
               cmd_take = 1'b1;
               if (is_none) begin
                  b_meta_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en             = 1'b1;
                  rd_addr           = wrap_add(front_ff, count_ff - 1'b1);
                  b_meta_in.use_mem = 1'b1;
                  count_in          = count_ff - 1'b1;
               end
            end
            deq_pkg::OP_TRAVERSE: begin
               if (is_none) begin
                  cmd_take         = 1'b1;
                  b_meta_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en             = 1'b1;
                  rd_addr           = wrap_add(front_ff, CW'(trav_ff));
                  b_meta_in.use_mem = 1'b1;
                  b_meta_in.last    = trav_last;
                  if (trav_last) begin
                     cmd_take = 1'b1;
                     trav_in  = '0;
                  end else begin
                     trav_in  = trav_ff + 1'b1;
                  end
               end
            end
            default: begin
               cmd_take = 1'b1;
            end
         endcase
      end
      b_meta_in.occupancy = deq_pkg::OCC_W'(count_in);
      b_meta_in.is_empty  = (count_in == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         trav_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         trav_ff    <= trav_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // result metadata stage
   always_ff @(posedge clock) begin
      b_meta_ff <= b_meta_in;
   end

   // circular store, one access per cycle with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd_data.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result beat toward the output queue
   always_comb begin
      res_valid          = b_valid_ff;
      res_data.element   = b_meta_ff.use_mem ? rd_data_ff : '0;
      res_data.status    = b_meta_ff.status;
      res_data.occupancy = b_meta_ff.occupancy;
      res_data.is_empty  = b_meta_ff.is_empty;
      res_data.last      = b_meta_ff.last;
   end

   // checks
   `DEQ_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "element count above depth")
   `DEQ_ASSERT(a_out_room, out_load <= (deq_pkg::RSP_LVL_W + 1)'(deq_pkg::RSP_SLOTS), "result queue overcommitted")
   `DEQ_ASSERT(a_trav_range, (trav_ff == '0) || (CW'(trav_ff) < count_ff), "traversal index past count")
   `DEQ_ASSERT_NEXT(a_pop_count, issue && !is_none && (cmd_data.op == deq_pkg::OP_POP_FRONT || cmd_data.op == deq_pkg::OP_POP_BACK), count_ff == $past(count_ff) - 1'b1, "pop did not drop count")

endmodule

// File: src/deq_rsp_queue.sv
// output queue: buffers result beats until the receiver pops them
module deq_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  deq_pkg::deq_rsp_type          res_data,
   output logic [deq_pkg::RSP_LVL_W-1:0] level,
   output logic                          empty,
   input  logic                          pop,
   output deq_pkg::deq_rsp_type          rsp_data
);

   deq_pkg::deq_rsp_type                 slot_ff [deq_pkg::RSP_SLOTS];
   logic [deq_pkg::RSP_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [deq_pkg::RSP_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [deq_pkg::RSP_LVL_W-1:0]        level_ff, level_in;
   logic                                 rd_fire;

   assign level    = level_ff;
   assign empty    = (level_ff == '0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign rd_fire  = pop && !empty;

   // pointer and level update; the back end never writes into a full queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (res_valid) begin
         wr_ptr_in = (wr_ptr_ff == deq_pkg::RSP_PTR_W'(deq_pkg::RSP_SLOTS - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == deq_pkg::RSP_PTR_W'(deq_pkg::RSP_SLOTS - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (res_valid && !rd_fire) begin
         level_in = level_ff + 1'b1;
      end else if (!res_valid && rd_fire) begin
         level_in = level_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (res_valid) begin
         slot_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

// File: src/double_ended_queue.sv
// top level of the double-ended queue of signed 32-bit words
//
// request side: a beat carrying kind and value is taken on an edge with push
// high and full low. kinds: push front, push back, pop front, pop back and
// traverse; other codes give one ok result and change nothing.
// result side: while empty is low the oldest result sits on rsp_data and is
// taken on an edge with pop high. every request yields one result, except a
// traverse of a non-empty queue, which yields one result per held element,
// front first, with last set on the final one.
// path: a request passes the command queue, the registered store step and the
// result queue before its first result is visible on rsp_data.
// throughput: one store step per cycle while the result queue has room, set by
// the single store port: one step per push, pop or empty/full answer, n per traverse of n.
// a stalled receiver fills the four-entry result queue, then the two-entry
// command queue, and then full rises; nothing is dropped.
// reset empties both queues and the store (count and front index to zero).
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  deq_pkg::deq_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output deq_pkg::deq_rsp_type rsp_data
);

   logic                          cmd_valid;
   deq_pkg::deq_cmd_type          cmd_data;
   logic                          cmd_take;
   logic [deq_pkg::RSP_LVL_W-1:0] rsp_level;
   logic                          res_valid;
   deq_pkg::deq_rsp_type          res_data;

   // request decode and command queue
   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // store and command execution
   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_level (rsp_level),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // result buffering
   deq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .level     (rsp_level),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/double_ended_queue_tb.sv
// self-checking testbench for the double-ended queue with a mirrored deque and random stalls
`timescale 1ns / 100ps

module double_ended_queue_tb;

   localparam int DEPTH          = 16;
   localparam int RESET_CYCLES   = 9;
   localparam int PHASE_ITEMS    = 32;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HANG_LIMIT     = 2000;

   // request codes the block treats as no-ops
   localparam logic [deq_pkg::KIND_W-1:0] KIND_FIRST_SPARE = 3'd5;
   localparam logic [deq_pkg::KIND_W-1:0] KIND_LAST_SPARE  = 3'd7;

   // mirror of the deque contents and the results each request should produce
   class deque_mirror;
      logic signed [deq_pkg::WORD_W-1:0] slots [DEPTH];
      int                                front;
      int                                count;
      deq_pkg::deq_rsp_type              due_results [$];
      int                                errors;

      function new();
         front  = 0;
         count  = 0;
         errors = 0;
      endfunction

      function void add_result(logic signed [deq_pkg::WORD_W-1:0] element,
                               logic [deq_pkg::STATUS_W-1:0] status, logic last);
         deq_pkg::deq_rsp_type rsp;
         rsp.element   = element;
         rsp.status    = status;
         rsp.occupancy = count[deq_pkg::OCC_W-1:0];
         rsp.is_empty  = (count == 0);
         rsp.last      = last;
         due_results.push_back(rsp);
      endfunction

      // apply one accepted request beat to the mirror
      function void apply_request(deq_pkg::deq_req_type req);
         logic signed [deq_pkg::WORD_W-1:0] word;
         case (req.kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  add_result('0, deq_pkg::ST_FULL, 1'b1);
               end else begin
                  if (req.kind == deq_pkg::KIND_PUSH_FRONT) begin
                     front = (front + DEPTH - 1) % DEPTH;
                     slots[front] = req.value;
                  end else begin
                     slots[(front + count) % DEPTH] = req.value;
                  end
                  count++;
                  add_result('0, deq_pkg::ST_OK, 1'b1);
               end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
               if (count == 0) begin
                  add_result('0, deq_pkg::ST_EMPTY, 1'b1);
               end else begin
                  if (req.kind == deq_pkg::KIND_POP_FRONT) begin
                     word  = slots[front];
                     front = (front + 1) % DEPTH;
                  end else begin
                     word = slots[(front + count - 1) % DEPTH];
                  end
                  count--;
                  add_result(word, deq_pkg::ST_OK, 1'b1);
               end
            end
            deq_pkg::KIND_TRAVERSE: begin
               if (count == 0) begin
                  add_result('0, deq_pkg::ST_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++)
                     add_result(slots[(front + i) % DEPTH], deq_pkg::ST_OK, i == count - 1);
               end
            end
            default: begin
               add_result('0, deq_pkg::ST_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_field(string field, logic [deq_pkg::WORD_W-1:0] want,
                                logic [deq_pkg::WORD_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      // compare one accepted result beat with the oldest due result
      function void compare_result(deq_pkg::deq_rsp_type got);
         deq_pkg::deq_rsp_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("element", want.element, got.element);
            check_field("status", deq_pkg::WORD_W'(want.status),
                        deq_pkg::WORD_W'(got.status));
            check_field("occupancy", deq_pkg::WORD_W'(want.occupancy),
                        deq_pkg::WORD_W'(got.occupancy));
            check_field("is_empty", deq_pkg::WORD_W'(want.is_empty),
                        deq_pkg::WORD_W'(got.is_empty));
            check_field("last", deq_pkg::WORD_W'(want.last), deq_pkg::WORD_W'(got.last));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 push;
   logic                 full;
   deq_pkg::deq_req_type req_data;
   logic                 empty;
   logic                 pop;
   deq_pkg::deq_rsp_type rsp_data;

   deque_mirror mirror;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          idle_cycles;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // clock generation
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // send one request beat, with a random idle gap in front of it
   task automatic send_beat(input logic [deq_pkg::KIND_W-1:0] kind,
                            input logic signed [deq_pkg::WORD_W-1:0] value);
      deq_pkg::deq_req_type beat;
      beat.kind  = kind;
      beat.value = value;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      mirror.apply_request(beat);
   endtask

   // result side: take beats and stall at random
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty)
            mirror.compare_result(rsp_data);
         pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // main stimulus
   initial begin
      int phase;
      int sent;
      int roll;
      int push_share;
      bit filling;
      int sender_idle_by_phase [4];
      int receiver_stall_by_phase [4];

      sender_idle_by_phase    = '{0, 69, 0, 38};
      receiver_stall_by_phase = '{0, 0, 69, 38};
      mirror             = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty queue answers and spare kinds
      send_beat(deq_pkg::KIND_POP_FRONT, $urandom);
      send_beat(deq_pkg::KIND_POP_BACK, $urandom);
      send_beat(deq_pkg::KIND_TRAVERSE, $urandom);
      for (int k = KIND_FIRST_SPARE; k <= KIND_LAST_SPARE; k++)
         send_beat(k[deq_pkg::KIND_W-1:0], $urandom);

      // fill to the top with the extreme words first
      send_beat(deq_pkg::KIND_PUSH_FRONT, 32'sh7FFFFFFF);
      send_beat(deq_pkg::KIND_PUSH_BACK, 32'sh80000000);
      send_beat(deq_pkg::KIND_PUSH_FRONT, 32'sh00000000);
      send_beat(deq_pkg::KIND_PUSH_BACK, 32'shFFFFFFFF);
      for (int i = 4; i < DEPTH; i++)
         send_beat((i % 2 != 0) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT,
                   $urandom);

      // refused pushes, full traverse, one pop from each end
      send_beat(deq_pkg::KIND_PUSH_FRONT, $urandom);
      send_beat(deq_pkg::KIND_PUSH_BACK, $urandom);
      send_beat(deq_pkg::KIND_TRAVERSE, $urandom);
      send_beat(deq_pkg::KIND_POP_FRONT, $urandom);
      send_beat(deq_pkg::KIND_POP_BACK, $urandom);

      // random phases: fill and drain sweeps with traverses and spare kinds mixed in
      filling = 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_idle_by_phase[phase];
         receiver_stall_pct = receiver_stall_by_phase[phase];
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (mirror.count >= DEPTH && $urandom_range(0, 3) != 0)
               filling = 1'b0;
            else if (mirror.count == 0 && $urandom_range(0, 3) != 0)
               filling = 1'b1;
            else if ($urandom_range(0, 99) < 3)
               filling = ~filling;
            push_share = filling ? 75 : 25;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               send_beat(deq_pkg::KIND_W'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE)),
                         $urandom);
            end else begin
               if (roll < 15)
                  send_beat(deq_pkg::KIND_TRAVERSE, $urandom);
               else if ($urandom_range(0, 99) < push_share)
                  send_beat($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK
                                                 : deq_pkg::KIND_PUSH_FRONT, $urandom);
               else
                  send_beat($urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK
                                                 : deq_pkg::KIND_POP_FRONT, $urandom);
               sent++;
            end
         end
      end
      push <= 1'b0;

      // drain and settle
      while (mirror.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.errors == 0 && mirror.due_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
